// ===== rtl/core/rldcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rldcs_pkg;

  localparam int LED_COUNT_DEF  = 3;
  localparam int DELAY_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int STEP_W     = 5;
  localparam int PCT_W      = 7;
  localparam int CMD_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DIMMING_ON  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ON_PERCENT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_PERCENT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_MAP   = 3'd5;

  localparam logic [2:0] CODE_STEP     = 3'd1;
  localparam logic [2:0] CODE_PWM0     = 3'd2;
  localparam logic [2:0] CODE_PWM1     = 3'd3;
  localparam logic [2:0] CODE_PWM2     = 3'd4;
  localparam logic [2:0] CODE_DIM_UP   = 3'd5;
  localparam logic [2:0] CODE_DIM_DOWN = 3'd6;
  localparam logic [2:0] CODE_DIM_TIME = 3'd7;

  localparam logic [1:0] KIND_NORM = 2'd0;
  localparam logic [1:0] KIND_UP   = 2'd1;
  localparam logic [1:0] KIND_DOWN = 2'd2;

  localparam logic [STEP_W-1:0] STEP_MAX = 5'd31;
  localparam logic [STEP_W-1:0] TICK_MAX = 5'd31;

  // 100 for the percent times 8 per current step
  localparam int SPAN_SCALE = 800;
  localparam int DIV_W      = 15;
  localparam int QBITS      = 5;

  localparam int NUM_SLOTS = 10;
  localparam int SLOT_W    = 4;
  localparam logic [SLOT_W-1:0] SLOT_PRE0 = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_PRE1 = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_PRE2 = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_A    = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_B    = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_GRP0 = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_GRP1 = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_GRP2 = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_C    = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_D    = 4'd9;

  typedef struct packed {
    logic              dimming_on;
    logic [STEP_W-1:0] low_step;
    logic [STEP_W-1:0] high_step;
    logic [PCT_W-1:0]  on_percent;
    logic [PCT_W-1:0]  off_percent;
    logic [8:0]        group_map;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{1'b1, 5'd6, 5'd31, 7'd50, 7'd50, 9'd268};

  typedef struct packed {
    logic [1:0]        kind;
    logic [2:0]        pre_mask;
    logic [2:0]        grp;
    logic [STEP_W-1:0] pwm;
  } cmd_hdr_t;

  localparam int HDR_W = $bits(cmd_hdr_t);

  function automatic logic [CMD_W-1:0] slot_cmd(input logic [SLOT_W-1:0] slot,
                                                input cmd_hdr_t hdr,
                                                input logic [STEP_W-1:0] tick,
                                                input cfg_t cfg);
    logic [2:0]        code;
    logic [STEP_W-1:0] val;
    code = CODE_DIM_TIME;
    val  = '0;
    case (slot)
      SLOT_PRE0: code = CODE_PWM0;
      SLOT_PRE1: code = CODE_PWM1;
      SLOT_PRE2: code = CODE_PWM2;
      SLOT_A: begin
        code = CODE_STEP;
        case (hdr.kind)
          KIND_UP:   val = cfg.low_step;
          KIND_DOWN: val = cfg.high_step;
          default:   val = STEP_MAX;
        endcase
      end
      SLOT_B: code = CODE_DIM_TIME;
      SLOT_GRP0: begin
        code = CODE_PWM0;
        val  = hdr.pwm;
      end
      SLOT_GRP1: begin
        code = CODE_PWM1;
        val  = hdr.pwm;
      end
      SLOT_GRP2: begin
        code = CODE_PWM2;
        val  = hdr.pwm;
      end
      SLOT_C: begin
        if (hdr.kind == KIND_DOWN) begin
          code = CODE_DIM_DOWN;
          val  = cfg.low_step;
        end else begin
          code = CODE_DIM_UP;
          val  = cfg.high_step;
        end
      end
      SLOT_D: begin
        code = CODE_DIM_TIME;
        val  = tick;
      end
      default: begin
        code = CODE_DIM_TIME;
        val  = '0;
      end
    endcase
    return {code, val};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rldcs_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rldcs_queue
  import rldcs_pkg::*;
#(
  parameter int DW    = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire logic [DW-1:0] push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output logic [DW-1:0]      pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rldcs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rldcs_front
  import rldcs_pkg::*;
#(
  parameter int LED_COUNT  = LED_COUNT_DEF,
  parameter int DELAY_BITS = DELAY_BITS_DEF,
  parameter int IN_W       = 40,
  parameter int PROD_W     = DELAY_BITS + PCT_W
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cfg_t            cfg,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [IN_W-1:0] in_tdata,
  output logic                 q_valid,
  input  wire logic            q_ready,
  output cmd_hdr_t             q_hdr,
  output logic [PROD_W-1:0]    q_prod
);

  localparam logic [1:0] LVL_OFF  = 2'd0;
  localparam logic [1:0] LVL_HALF = 2'd1;
  localparam logic [1:0] LVL_FULL = 2'd2;
  localparam logic [1:0] LVL_BAD  = 2'd3;
  localparam logic [STEP_W-1:0] PWM_HALF = 5'd11;
  localparam logic [STEP_W-1:0] PWM_FULL = 5'd31;

  logic [STEP_W-1:0]     stored_r   [LED_COUNT];
  logic [STEP_W-1:0]     stored_nxt [LED_COUNT];
  logic [1:0]            led_idx, lvl;
  logic [DELAY_BITS-1:0] d_on, d_off, d_sel;
  logic [PCT_W-1:0]      pct_sel;
  logic [STEP_W-1:0]     pwm, stored_sel;
  logic [2:0]            grp;
  logic                  ignore, blinking, accept;
  logic [1:0]            kind;

  assign led_idx = in_tdata[1:0];
  assign lvl     = in_tdata[3:2];
  assign d_on    = in_tdata[4 +: DELAY_BITS];
  assign d_off   = in_tdata[4 + DELAY_BITS +: DELAY_BITS];

  assign in_tready = q_ready;
  assign accept    = in_tvalid && q_ready;
  assign ignore    = (led_idx >= 2'(LED_COUNT)) || (lvl == LVL_BAD);
  assign blinking  = (|d_on) && (|d_off);

  always_comb begin
    case (lvl)
      LVL_FULL: pwm = PWM_FULL;
      LVL_HALF: pwm = PWM_HALF;
      default:  pwm = '0;
    endcase
    case (led_idx)
      2'd0:    grp = cfg.group_map[2:0];
      2'd1:    grp = cfg.group_map[5:3];
      default: grp = cfg.group_map[8:6];
    endcase
    stored_sel = '0;
    for (int i = 0; i < LED_COUNT; i++) begin
      if (led_idx == 2'(i)) begin
        stored_sel = stored_r[i];
      end
    end
    if (cfg.dimming_on && blinking) begin
      kind = (lvl != LVL_OFF) ? KIND_UP : KIND_DOWN;
    end else begin
      kind = KIND_NORM;
    end
    d_sel   = (kind == KIND_DOWN) ? d_off : d_on;
    pct_sel = (kind == KIND_DOWN) ? cfg.off_percent : cfg.on_percent;
  end

  always_comb begin
    q_hdr.kind     = kind;
    q_hdr.pre_mask = (cfg.dimming_on && lvl != LVL_OFF) ? ~grp : 3'b000;
    q_hdr.grp      = grp;
    q_hdr.pwm      = (kind == KIND_DOWN) ? stored_sel : pwm;
    q_prod         = PROD_W'(d_sel) * PROD_W'(pct_sel);
    q_valid        = in_tvalid && !ignore;
  end

  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      stored_nxt[i] = stored_r[i];
      if (accept && !ignore && kind == KIND_UP && led_idx == 2'(i)) begin
        stored_nxt[i] = pwm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        stored_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < LED_COUNT; i++) begin
        stored_r[i] <= stored_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rldcs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rldcs_back
  import rldcs_pkg::*;
#(
  parameter int PROD_W = DELAY_BITS_DEF + PCT_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire cmd_hdr_t          q_hdr,
  input  wire logic [PROD_W-1:0] q_prod,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [CMD_W-1:0]       out_tdata,
  output logic                   out_tlast
);

  localparam int SDIV_W = DIV_W + QBITS;
  localparam int CMP_W  = (PROD_W > SDIV_W) ? PROD_W : SDIV_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]           state_r, state_nxt;
  cmd_hdr_t             hdr_r, hdr_nxt;
  logic [PROD_W-1:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]     div_r, div_nxt;
  logic [2:0]           bit_r, bit_nxt;
  logic [STEP_W-1:0]    tick_r, tick_nxt;
  logic [NUM_SLOTS-1:0] mask_r, mask_nxt, mask_clr;
  logic                 out_valid_r, out_valid_nxt;
  logic [CMD_W-1:0]     out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [STEP_W-1:0]    span;
  logic                 steps_ok, out_free, run_norm;
  logic [DIV_W-1:0]     div_calc;
  logic [CMP_W-1:0]     rem_ext, sat_div, cur_div;
  logic [SLOT_W-1:0]    sel;

  assign span     = cfg.high_step - cfg.low_step;
  assign steps_ok = cfg.high_step > cfg.low_step;
  assign div_calc = DIV_W'(span) * DIV_W'(SPAN_SCALE);
  assign rem_ext  = CMP_W'(rem_r);
  assign sat_div  = CMP_W'({div_r, QBITS'(0)});
  assign cur_div  = CMP_W'(div_r) << bit_r;
  assign out_free = !out_valid_r || out_tready;
  assign run_norm = (q_hdr.kind == KIND_NORM);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = SLOT_W'(i);
      end
    end
    mask_clr = mask_r & ~(NUM_SLOTS'(1) << sel);
  end

  always_comb begin
    state_nxt     = state_r;
    hdr_nxt       = hdr_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    bit_nxt       = bit_r;
    tick_nxt      = tick_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    q_ready       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          hdr_nxt  = q_hdr;
          rem_nxt  = q_prod;
          div_nxt  = div_calc;
          tick_nxt = '0;
          mask_nxt = {!run_norm, !run_norm, q_hdr.grp, run_norm, 1'b1, q_hdr.pre_mask};
          state_nxt = (run_norm || !steps_ok) ? ST_EMIT : ST_SAT;
        end
      end
      ST_SAT: begin
        if (rem_ext >= sat_div) begin
          tick_nxt  = TICK_MAX;
          state_nxt = ST_EMIT;
        end else begin
          bit_nxt   = 3'(QBITS - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_ext >= cur_div) begin
          rem_nxt  = rem_r - PROD_W'(cur_div);
          tick_nxt = tick_r | (STEP_W'(1) << bit_r);
        end
        if (bit_r == 3'd0) begin
          state_nxt = ST_EMIT;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = slot_cmd(sel, hdr_r, tick_r, cfg);
          out_last_nxt  = (mask_clr == '0);
          mask_nxt      = mask_clr;
          if (mask_clr == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r      <= hdr_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    bit_r      <= bit_nxt;
    tick_r     <= tick_nxt;
    mask_r     <= mask_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/rgb_led_dimming_command_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// in_       slave      in_tvalid / in_tready  in_tdata: led_index, level, blink_on_ms, off_ms
// out_      master     out_tvalid / out_tready out_tdata: command; out_tlast: last
// cfg_      slave      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front classifies a request in its accept cycle and puts it in a two-entry queue.
// The back loads a request, divides a dim time when one is needed (saturation
// check, then one quotient bit per cycle), then emits its bytes while out_tready allows.
// Reset loads the register defaults and clears stored levels, queue and output valid.
// A low out_tready holds the output byte; the front keeps accepting until the queue fills.
module rgb_led_dimming_command_sequencer
  import rldcs_pkg::*;
#(
  parameter int LED_COUNT  = LED_COUNT_DEF,
  parameter int DELAY_BITS = DELAY_BITS_DEF,
  localparam int IN_W      = ((4 + 2 * DELAY_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // led_index[1:0], level[3:2], blink_on_ms, blink_off_ms, zero pad
  input  wire logic [IN_W-1:0]       in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // command[7:0]
  output logic [CMD_W-1:0]           out_tdata,
  output logic                       out_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PROD_W = DELAY_BITS + PCT_W;
  localparam int QW     = HDR_W + PROD_W;

  cfg_t              cfg_r, cfg_nxt;
  logic              f_valid, f_ready;
  cmd_hdr_t          f_hdr, b_hdr;
  logic [PROD_W-1:0] f_prod, b_prod;
  logic              b_valid, b_ready;
  logic [QW-1:0]     b_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_DIMMING_ON:  cfg_nxt.dimming_on  = cfg_data[0];
        REG_LOW_STEP:    cfg_nxt.low_step    = cfg_data[STEP_W-1:0];
        REG_HIGH_STEP:   cfg_nxt.high_step   = cfg_data[STEP_W-1:0];
        REG_ON_PERCENT:  cfg_nxt.on_percent  = cfg_data[PCT_W-1:0];
        REG_OFF_PERCENT: cfg_nxt.off_percent = cfg_data[PCT_W-1:0];
        REG_GROUP_MAP:   cfg_nxt.group_map   = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rldcs_front #(
    .LED_COUNT  (LED_COUNT),
    .DELAY_BITS (DELAY_BITS),
    .IN_W       (IN_W),
    .PROD_W     (PROD_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_hdr     (f_hdr),
    .q_prod    (f_prod)
  );

  rldcs_queue #(
    .DW    (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_prod, f_hdr}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  assign b_hdr  = b_data[HDR_W-1:0];
  assign b_prod = b_data[QW-1:HDR_W];

  rldcs_back #(
    .PROD_W (PROD_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_hdr      (b_hdr),
    .q_prod     (b_prod),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (f_valid && f_ready) |-> (in_tvalid && in_tready))
    else $error("queue written without an accepted input word");

  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid && b_ready) |=> !(b_valid && b_ready))
    else $error("back end took two requests in consecutive cycles");

endmodule

`default_nettype wire

// ===== dv/rgb_led_dimming_command_sequencer_tb.sv =====
`timescale 1ns / 1ps

module rgb_led_dimming_command_sequencer_tb;
  import rldcs_pkg::*;

  localparam int LED_COUNT = LED_COUNT_DEF;
  localparam int IN_W      = ((4 + 2 * DELAY_BITS_DEF + 7) / 8) * 8;
  localparam logic [STEP_W-1:0] PWM_HALF = 5'd11;
  localparam logic [STEP_W-1:0] PWM_FULL = 5'd31;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;

  typedef enum logic [1:0] {LVL_OFF, LVL_HALF, LVL_FULL, LVL_BAD} level_e;

  class cmd_scoreboard;
    cfg_t              cfg;
    logic [STEP_W-1:0] latched_pwm [LED_COUNT];
    logic [CMD_W:0]    cmd_q [$];
    int unsigned       mismatches;

    function new();
      cfg = CFG_RESET;
      foreach (latched_pwm[i]) latched_pwm[i] = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DIMMING_ON:  cfg.dimming_on  = data[0];
        REG_LOW_STEP:    cfg.low_step    = data[STEP_W-1:0];
        REG_HIGH_STEP:   cfg.high_step   = data[STEP_W-1:0];
        REG_ON_PERCENT:  cfg.on_percent  = data[PCT_W-1:0];
        REG_OFF_PERCENT: cfg.off_percent = data[PCT_W-1:0];
        REG_GROUP_MAP:   cfg.group_map   = data;
        default: ;
      endcase
    endfunction

    function logic [STEP_W-1:0] ramp_ticks(logic [15:0] delay_ms, logic [PCT_W-1:0] pct);
      int unsigned scaled, span, q;
      if (cfg.high_step <= cfg.low_step) return '0;
      scaled = (32'(delay_ms) * 32'(pct)) / 100;
      span   = (32'(cfg.high_step) - 32'(cfg.low_step)) * 8;
      q      = scaled / span;
      return (q > 31) ? TICK_MAX : q[STEP_W-1:0];
    endfunction

    function void push_cmd(logic [2:0] code, logic [STEP_W-1:0] val);
      cmd_q.push_back({1'b0, code, val});
    endfunction

    function void push_group(logic [2:0] mask, logic [STEP_W-1:0] val);
      for (int c = 0; c < 3; c++)
        if (mask[c]) push_cmd(CODE_PWM0 + 3'(c), val);
    endfunction

    function void note_request(logic [IN_W-1:0] word);
      logic [1:0]        led;
      level_e            lvl;
      logic [15:0]       on_ms, off_ms;
      logic [2:0]        grp;
      logic [STEP_W-1:0] pwm;
      logic [CMD_W:0]    tail;
      bit                blinking;
      led    = word[1:0];
      lvl    = level_e'(word[3:2]);
      on_ms  = word[19:4];
      off_ms = word[35:20];
      if (led >= LED_COUNT || lvl == LVL_BAD) return;
      case (lvl)
        LVL_FULL: pwm = PWM_FULL;
        LVL_HALF: pwm = PWM_HALF;
        default:  pwm = '0;
      endcase
      grp      = cfg.group_map[3 * led +: 3];
      blinking = (on_ms != 0) && (off_ms != 0);
      if (cfg.dimming_on && lvl != LVL_OFF) push_group(~grp, '0);
      if (cfg.dimming_on && blinking) begin
        if (lvl != LVL_OFF) begin
          push_cmd(CODE_STEP, cfg.low_step);
          push_group(grp, pwm);
          latched_pwm[led] = pwm;
          push_cmd(CODE_DIM_UP, cfg.high_step);
          push_cmd(CODE_DIM_TIME, ramp_ticks(on_ms, cfg.on_percent));
        end else begin
          push_cmd(CODE_STEP, cfg.high_step);
          push_group(grp, latched_pwm[led]);
          push_cmd(CODE_DIM_DOWN, cfg.low_step);
          push_cmd(CODE_DIM_TIME, ramp_ticks(off_ms, cfg.off_percent));
        end
      end else begin
        push_cmd(CODE_STEP, STEP_MAX);
        push_cmd(CODE_DIM_TIME, '0);
        push_group(grp, pwm);
      end
      tail = cmd_q.pop_back();
      tail[CMD_W] = 1'b1;
      cmd_q.push_back(tail);
    endfunction

    function void report(string what, logic [CMD_W:0] exp_w, logic [CMD_W:0] got_w);
      if (mismatches < 10)
        $display("%0t %s: expected cmd %02h last %0b, got cmd %02h last %0b", $realtime,
                 what, exp_w[CMD_W-1:0], exp_w[CMD_W], got_w[CMD_W-1:0], got_w[CMD_W]);
      mismatches++;
    endfunction

    function void check_result(logic [CMD_W-1:0] cmd, logic last);
      logic [CMD_W:0] exp_w;
      if (cmd_q.size() == 0) begin
        report("unexpected word", 'x, {last, cmd});
        return;
      end
      exp_w = cmd_q.pop_front();
      if (exp_w[CMD_W-1:0] !== cmd || exp_w[CMD_W] !== last)
        report("word mismatch", exp_w, {last, cmd});
    endfunction

    function void check_leftover();
      while (cmd_q.size() != 0) report("missing word", cmd_q.pop_front(), 'x);
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [CMD_W-1:0]      out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  cmd_scoreboard sb;
  bit idle_on     = 1'b1;
  bit hold_off_rq = 1'b0;

  rgb_led_dimming_command_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("rgb_led_dimming_command_sequencer_tb failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    wait (rst_n);
    forever begin
      if (hold_off_rq) begin
        hold_off_rq = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic logic [15:0] any_delay();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 16'hffff;
      2:       return 16'($urandom_range(1, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] blink_delay();
    logic [15:0] d;
    d = any_delay();
    return (d == 0) ? 16'd1 : d;
  endfunction

  task automatic send_request(logic [1:0] led, level_e lvl, logic [15:0] on_ms,
                              logic [15:0] off_ms);
    logic [IN_W-1:0] word;
    word = '0;
    word[1:0]   = led;
    word[3:2]   = lvl;
    word[19:4]  = on_ms;
    word[35:20] = off_ms;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    sb.note_request(word);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(cfg_t s);
    write_reg(REG_DIMMING_ON, CFG_DATA_W'(s.dimming_on));
    write_reg(REG_LOW_STEP, CFG_DATA_W'(s.low_step));
    write_reg(REG_HIGH_STEP, CFG_DATA_W'(s.high_step));
    write_reg(REG_ON_PERCENT, CFG_DATA_W'(s.on_percent));
    write_reg(REG_OFF_PERCENT, CFG_DATA_W'(s.off_percent));
    write_reg(REG_GROUP_MAP, s.group_map);
    cfg_valid <= 1'b0;
  endtask

  // drop valid, let every pending word drain, then let the back end go quiet
  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    for (int k = 0; k < 50000 && sb.cmd_q.size() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_requests(int count);
    int         done;
    logic [1:0] led;
    done = 0;
    while (done < count) begin
      case ($urandom_range(0, 7))
        0: begin
          if ($urandom_range(0, 1))
            send_request(2'd3, level_e'($urandom_range(0, 3)), any_delay(), any_delay());
          else
            send_request(2'($urandom_range(0, 3)), LVL_BAD, any_delay(), any_delay());
        end
        1, 2, 3, 4: begin
          led = 2'($urandom_range(0, LED_COUNT - 1));
          send_request(led, level_e'($urandom_range(1, 2)), blink_delay(), blink_delay());
          send_request(led, LVL_OFF, blink_delay(), blink_delay());
          done += 2;
        end
        default: begin
          send_request(2'($urandom_range(0, LED_COUNT - 1)), level_e'($urandom_range(0, 2)),
                       any_delay(), any_delay());
          done++;
        end
      endcase
    end
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    s.dimming_on  = ($urandom_range(0, 3) != 0);
    s.low_step    = 5'($urandom_range(0, 31));
    s.high_step   = 5'($urandom_range(0, 31));
    s.on_percent  = 7'($urandom_range(0, 127));
    s.off_percent = 7'($urandom_range(0, 127));
    s.group_map   = 9'($urandom_range(0, 511));
    return s;
  endfunction

  initial begin
    cfg_t phase_cfg [6];
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(2'd0, LVL_FULL, 16'd0, 16'd0);
    send_request(2'd0, LVL_FULL, 16'd1000, 16'd1000);
    send_request(2'd0, LVL_OFF, 16'd1000, 16'd1000);
    send_request(2'd1, LVL_HALF, 16'hffff, 16'hffff);
    send_request(2'd1, LVL_OFF, 16'hffff, 16'hffff);
    send_request(2'd2, LVL_OFF, 16'd0, 16'd0);
    send_request(2'd2, LVL_OFF, 16'd1, 16'd1);
    send_request(2'd2, LVL_HALF, 16'd1, 16'd0);
    send_request(2'd2, LVL_FULL, 16'd0, 16'hffff);
    send_request(2'd3, LVL_HALF, 16'd500, 16'd500);
    send_request(2'd0, LVL_BAD, 16'd500, 16'd500);
    send_request(2'd3, LVL_BAD, 16'hffff, 16'hffff);
    wait_for_idle();

    apply_settings('{dimming_on: 1'b1, low_step: 5'd31, high_step: 5'd0,
                     on_percent: 7'd127, off_percent: 7'd127, group_map: 9'd0});
    send_request(2'd0, LVL_FULL, 16'hffff, 16'hffff);
    send_request(2'd0, LVL_OFF, 16'hffff, 16'hffff);
    send_request(2'd1, LVL_HALF, 16'd0, 16'd0);
    wait_for_idle();

    apply_settings('{dimming_on: 1'b1, low_step: 5'd0, high_step: 5'd31,
                     on_percent: 7'd127, off_percent: 7'd100, group_map: 9'h1ff});
    send_request(2'd2, LVL_FULL, 16'hffff, 16'hffff);
    send_request(2'd2, LVL_OFF, 16'hffff, 16'hffff);
    send_request(2'd1, LVL_HALF, 16'd40000, 16'd1);
    wait_for_idle();

    apply_settings('{dimming_on: 1'b1, low_step: 5'd30, high_step: 5'd31,
                     on_percent: 7'd100, off_percent: 7'd0, group_map: 9'd268});
    send_request(2'd0, LVL_FULL, 16'hffff, 16'd3);
    send_request(2'd0, LVL_OFF, 16'd3, 16'hffff);
    wait_for_idle();

    phase_cfg[0] = CFG_RESET;
    phase_cfg[1] = '{dimming_on: 1'b1, low_step: 5'd0, high_step: 5'd31,
                     on_percent: 7'd100, off_percent: 7'd0, group_map: 9'h1ff};
    phase_cfg[2] = '{dimming_on: 1'b0, low_step: 5'd31, high_step: 5'd0,
                     on_percent: 7'd0, off_percent: 7'd127, group_map: 9'd0};
    phase_cfg[3] = random_settings();
    phase_cfg[4] = '{dimming_on: 1'b1, low_step: 5'd0, high_step: 5'd1,
                     on_percent: 7'd127, off_percent: 7'd127,
                     group_map: 9'($urandom_range(0, 511))};
    phase_cfg[5] = '{dimming_on: 1'b1, low_step: 5'd4, high_step: 5'd20,
                     on_percent: 7'd63, off_percent: 7'd37, group_map: 9'd268};

    foreach (phase_cfg[p]) begin
      apply_settings(phase_cfg[p]);
      if (p == 1) hold_off_rq = 1'b1;
      if (p == 5) idle_on = 1'b0;
      random_requests(70);
      wait_for_idle();
    end

    sb.check_leftover();
    if (sb.mismatches == 0)
      $display("rgb_led_dimming_command_sequencer_tb passed");
    else
      $display("rgb_led_dimming_command_sequencer_tb failed");
    $finish;
  end

endmodule

// ===== rgb_led_dimming_command_sequencer.f =====
rtl/core/rldcs_pkg.sv
rtl/core/rldcs_queue.sv
rtl/core/rldcs_front.sv
rtl/core/rldcs_back.sv
rtl/core/rgb_led_dimming_command_sequencer.sv
dv/rgb_led_dimming_command_sequencer_tb.sv
